// ===== design/pva_pkg.sv =====
// Shared types, constants and pitch helpers for the polyphonic voice allocator.
package pva_pkg;

    // Default number of voices in the table
    localparam int VOICES_DEF = 8;

    // Depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    // Command codes carried in the cmd field
    localparam logic CMD_NOTE_OFF = 1'b0;
    localparam logic CMD_NOTE_ON  = 1'b1;

    // Semitones per octave
    localparam int SEMIS = 12;

    // Width of the octave-zero increment table entries (Q16)
    localparam int INC_TBL_W = 27;

    // Classified request passed from the front part to the back part
    typedef struct packed {
        logic       note_on;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [3:0] octave;
        logic [3:0] semitone;
    } cmd_entry_t;

    // Split a MIDI note into its octave (note / 12)
    function automatic logic [3:0] note_octave(input logic [6:0] note);
        logic [3:0] oct;
        oct = 4'd0;
        for (int k = 1; k <= 10; k++) begin
            if (note >= 7'(SEMIS * k)) begin
                oct = oct + 4'd1;
            end
        end
        return oct;
    endfunction

    // Remainder of the note within its octave
    function automatic logic [3:0] note_semitone(input logic [6:0] note,
                                                 input logic [3:0] oct);
        logic [6:0] base;
        logic [6:0] rem;
        base = 7'(oct) * 7'd12;
        rem  = note - base;
        return rem[3:0];
    endfunction

    // Octave-zero phase increment of each semitone, 16 fractional bits
    function automatic logic [INC_TBL_W-1:0] semitone_inc(input logic [3:0] semi);
        logic [INC_TBL_W-1:0] val;
        case (semi)
            4'd0:    val = 27'd46025656;
            4'd1:    val = 27'd48762484;
            4'd2:    val = 27'd51662052;
            4'd3:    val = 27'd54734038;
            4'd4:    val = 27'd57988693;
            4'd5:    val = 27'd61436880;
            4'd6:    val = 27'd65090107;
            4'd7:    val = 27'd68960566;
            4'd8:    val = 27'd73061175;
            4'd9:    val = 27'd77405619;
            4'd10:   val = 27'd82008396;
            4'd11:   val = 27'd86884869;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== design/pva_event_if.sv =====
// Note event channel: valid/ready handshake with cmd, note and velocity.
interface pva_event_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [6:0] note;
    logic [6:0] velocity;

    modport source (output valid, output cmd, output note, output velocity, input ready);
    modport sink   (input valid, input cmd, input note, input velocity, output ready);
endinterface

// ===== design/pva_result_if.sv =====
// Voice result channel: valid/ready handshake with allocation outcome.
interface pva_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [2:0]  voice_index;
    logic        gate;
    logic [31:0] phase_increment;

    modport source (output valid, output found, output voice_index, output gate,
                    output phase_increment, input ready);
    modport sink   (input valid, input found, input voice_index, input gate,
                    input phase_increment, output ready);
endinterface

// ===== design/pva_queue.sv =====
// Short FIFO that decouples the front classifier from the voice table.
module pva_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  pva_pkg::cmd_entry_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output pva_pkg::cmd_entry_t pop_data
);
    localparam int DEPTH = pva_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pva_pkg::cmd_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed requests
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/pva_front.sv =====
// Front part: accepts note events and splits the note into octave and semitone.
module pva_front (
    pva_event_if.sink           events,
    output logic                push_valid,
    input  logic                push_ready,
    output pva_pkg::cmd_entry_t push_data
);
    logic [3:0] octave;

    // Take a request whenever the queue has room
    assign events.ready = push_ready;
    assign push_valid   = events.valid;

    // Classify the request
    assign octave = pva_pkg::note_octave(events.note);

    always_comb
    begin
        push_data.note_on  = (events.cmd == pva_pkg::CMD_NOTE_ON);
        push_data.note     = events.note;
        push_data.velocity = events.velocity;
        push_data.octave   = octave;
        push_data.semitone = pva_pkg::note_semitone(events.note, octave);
    end

endmodule

// ===== design/pva_back.sv =====
// Back part: voice table search and update, pitch increment, result register.
module pva_back #(
    parameter int VOICES = pva_pkg::VOICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  pva_pkg::cmd_entry_t pop_data,
    pva_result_if.source        results
);
    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SHF_W = 48;

    logic [VOICES-1:0] active_reg, active_next;
    logic [6:0]        note_reg [VOICES];
    logic [6:0]        note_next [VOICES];
    logic [6:0]        vel_reg [VOICES];
    logic [6:0]        vel_next [VOICES];

    logic              out_valid_reg;
    logic              found_reg, found_next;
    logic [2:0]        index_reg, index_next;
    logic              gate_reg, gate_next;
    logic [31:0]       phase_reg, phase_next;

    logic              do_pop;
    logic              free_hit, match_hit;
    logic [IDX_W-1:0]  free_idx, match_idx;
    logic [IDX_W+2:0]  idx_wide;
    logic [SHF_W-1:0]  inc_shifted;
    logic              table_clean;

    assign pop_ready = !out_valid_reg || results.ready;
    assign do_pop    = pop_valid && pop_ready;

    // Find the lowest free voice and the lowest active voice on this note
    always_comb
    begin
        free_hit  = 1'b0;
        free_idx  = '0;
        match_hit = 1'b0;
        match_idx = '0;
        for (int v = VOICES - 1; v >= 0; v--) begin
            if (!active_reg[v]) begin
                free_hit = 1'b1;
                free_idx = IDX_W'(v);
            end
            if (active_reg[v] && (note_reg[v] == pop_data.note)) begin
                match_hit = 1'b1;
                match_idx = IDX_W'(v);
            end
        end
    end

    // Scale the octave-zero increment by the octave and drop the fraction
    assign inc_shifted = SHF_W'(pva_pkg::semitone_inc(pop_data.semitone)) << pop_data.octave;

    // Build the result and the table update
    always_comb
    begin
        active_next = active_reg;
        note_next   = note_reg;
        vel_next    = vel_reg;
        found_next  = 1'b0;
        idx_wide    = '0;
        gate_next   = 1'b0;
        phase_next  = '0;
        if (pop_data.note_on)
        begin
            if (free_hit)
            begin
                active_next[free_idx] = 1'b1;
                note_next[free_idx]   = pop_data.note;
                vel_next[free_idx]    = pop_data.velocity;
                found_next            = 1'b1;
                idx_wide              = {3'b000, free_idx};
                gate_next             = 1'b1;
                phase_next            = inc_shifted[47:16];
            end
        end
        else
        begin
            if (match_hit)
            begin
                active_next[match_idx] = 1'b0;
                note_next[match_idx]   = '0;
                vel_next[match_idx]    = '0;
                found_next             = 1'b1;
                idx_wide               = {3'b000, match_idx};
            end
        end
        index_next = idx_wide[2:0];
    end

    // Hold the voice table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            for (int v = 0; v < VOICES; v++) begin
                note_reg[v] <= '0;
                vel_reg[v]  <= '0;
            end
        end
        else if (do_pop)
        begin
            active_reg <= active_next;
            note_reg   <= note_next;
            vel_reg    <= vel_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            found_reg <= found_next;
            index_reg <= index_next;
            gate_reg  <= gate_next;
            phase_reg <= phase_next;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.found           = found_reg;
    assign results.voice_index     = index_reg;
    assign results.gate            = gate_reg;
    assign results.phase_increment = phase_reg;

    // Free voices keep a cleared note and velocity
    always_comb
    begin
        table_clean = 1'b1;
        for (int v = 0; v < VOICES; v++) begin
            if (!active_reg[v] && ((note_reg[v] != '0) || (vel_reg[v] != '0))) begin
                table_clean = 1'b0;
            end
        end
    end

    a_table_clean: assert property (@(posedge clk) disable iff (!rst_n) table_clean)
        else $error("free voice holds stale note or velocity");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> (index_reg == '0) && !gate_reg && (phase_reg == '0))
        else $error("not-found result carries nonzero fields");

    a_gate_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && gate_reg |-> found_reg && (phase_reg != '0))
        else $error("claimed voice without pitch");

    a_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && pop_data.note_on && (&active_reg) |=> out_valid_reg && !found_reg)
        else $error("note-on claimed a voice while the table was full");

endmodule

// ===== design/polyphonic_voice_allocator.sv =====
// Top level of the polyphonic voice allocator: front, queue and voice table.
//
// Requests arrive on note_events (cmd, note, velocity) and each one yields
// exactly one result on voice_results (found, voice_index, gate,
// phase_increment). A note-on claims the lowest free voice and returns its
// index with the oscillator phase increment; a note-off frees the lowest
// active voice on that note. When no voice qualifies, found is 0 and the
// other result fields are 0.
// A request accepted from note_events is written into the queue; the back
// part takes it from there and registers its result, which then stays
// valid until voice_results takes it.
// Throughput: one request per cycle while voice_results.ready is high, as
// the search and update of the voice table in the back part is combinational.
// A two-entry queue sits between the front and back parts. When the
// receiver stalls, the result register holds, the queue fills, and
// note_events.ready falls once the queue is full.
// Reset (rst_n low, asynchronous) frees every voice and empties the queue.
module polyphonic_voice_allocator #(
    parameter int VOICES = pva_pkg::VOICES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pva_event_if.sink    note_events,
    pva_result_if.source voice_results
);
    logic                push_valid, push_ready;
    logic                pop_valid, pop_ready;
    pva_pkg::cmd_entry_t push_data, pop_data;

    pva_front u_front (
        .events     (note_events),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    pva_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pva_back #(
        .VOICES (VOICES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .results   (voice_results)
    );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the polyphonic voice allocator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VOICES      = pva_pkg::VOICES_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 1800;
    localparam int MAX_REPORTS = 10;

    // Octave-zero phase step per semitone, Q16
    localparam logic [26:0] OCT0_STEP [12] = '{
        27'd46025656, 27'd48762484, 27'd51662052, 27'd54734038,
        27'd57988693, 27'd61436880, 27'd65090107, 27'd68960566,
        27'd73061175, 27'd77405619, 27'd82008396, 27'd86884869
    };

    typedef struct packed {
        logic       cmd;
        logic [6:0] note;
        logic [6:0] velocity;
        logic       drain_first;
    } note_request_t;

    typedef struct packed {
        logic        found;
        logic [2:0]  voice_index;
        logic        gate;
        logic [31:0] phase_increment;
    } voice_outcome_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic       ev_valid  = 1'b0;
    logic       ev_cmd    = pva_pkg::CMD_NOTE_OFF;
    logic [6:0] ev_note   = '0;
    logic [6:0] ev_vel    = '0;
    logic       res_ready = 1'b0;

    pva_event_if  note_events ();
    pva_result_if voice_results ();

    assign note_events.valid    = ev_valid;
    assign note_events.cmd      = ev_cmd;
    assign note_events.note     = ev_note;
    assign note_events.velocity = ev_vel;
    assign voice_results.ready  = res_ready;

    polyphonic_voice_allocator #(.VOICES(VOICES)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .note_events   (note_events),
        .voice_results (voice_results)
    );

    // Shadow voice table
    logic       voice_busy  [VOICES];
    logic [6:0] voice_pitch [VOICES];
    logic [6:0] voice_vel   [VOICES];

    note_request_t  pending_requests [$];
    voice_outcome_t outcome_q [$];
    note_request_t  next_req;

    int  requests_sent = 0;
    int  results_seen  = 0;
    int  mismatches    = 0;
    int  cycle_count   = 0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;

    always #5 clk = ~clk;

    // Phase step for a note: semitone entry shifted by octave, fraction dropped
    function automatic logic [31:0] pitch_step(input logic [6:0] note);
        int          octave;
        int          semi;
        logic [63:0] scaled;
        octave = note / 12;
        semi   = note % 12;
        scaled = 64'(OCT0_STEP[semi]) << octave;
        return scaled[47:16];
    endfunction

    // Apply one request to the shadow table and return its outcome
    function automatic voice_outcome_t allocate_voice(input logic cmd,
                                                      input logic [6:0] note,
                                                      input logic [6:0] velocity);
        voice_outcome_t res;
        res = '0;
        if (cmd == pva_pkg::CMD_NOTE_ON) begin
            for (int v = 0; v < VOICES; v++) begin
                if (!voice_busy[v]) begin
                    voice_busy[v]       = 1'b1;
                    voice_pitch[v]      = note;
                    voice_vel[v]        = velocity;
                    res.found           = 1'b1;
                    res.voice_index     = 3'(v);
                    res.gate            = 1'b1;
                    res.phase_increment = pitch_step(note);
                    break;
                end
            end
        end else begin
            for (int v = 0; v < VOICES; v++) begin
                if (voice_busy[v] && voice_pitch[v] == note) begin
                    voice_busy[v]   = 1'b0;
                    voice_pitch[v]  = '0;
                    voice_vel[v]    = '0;
                    res.found       = 1'b1;
                    res.voice_index = 3'(v);
                    break;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                   input logic [31:0] act_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] result %0d: %s expected 0x%0h got 0x%0h",
                     $realtime, results_seen, field, exp_val, act_val);
        end
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_result();
        voice_outcome_t exp_res;
        if (outcome_q.size() == 0) begin
            report_mismatch("unexpected result, found", 32'd0, 32'(voice_results.found));
        end else begin
            exp_res = outcome_q.pop_front();
            if (voice_results.found !== exp_res.found)
                report_mismatch("found", 32'(exp_res.found), 32'(voice_results.found));
            if (voice_results.voice_index !== exp_res.voice_index)
                report_mismatch("voice_index", 32'(exp_res.voice_index),
                                32'(voice_results.voice_index));
            if (voice_results.gate !== exp_res.gate)
                report_mismatch("gate", 32'(exp_res.gate), 32'(voice_results.gate));
            if (voice_results.phase_increment !== exp_res.phase_increment)
                report_mismatch("phase_increment", exp_res.phase_increment,
                                voice_results.phase_increment);
        end
        results_seen++;
    endtask

    task automatic queue_request(input logic cmd, input int note, input int velocity,
                                 input bit drain_first);
        note_request_t req;
        req.cmd         = cmd;
        req.note        = 7'(note);
        req.velocity    = 7'(velocity);
        req.drain_first = drain_first;
        pending_requests.push_back(req);
    endtask

    // Request driver: predict on acceptance, then present the next request
    always @(posedge clk) begin
        if (!rst_n) begin
            ev_valid <= 1'b0;
        end else begin
            if (ev_valid && note_events.ready) begin
                outcome_q.push_back(allocate_voice(ev_cmd, ev_note, ev_vel));
                requests_sent++;
            end
            if (!ev_valid || note_events.ready) begin
                if (pending_requests.size() > 0
                    && !(pending_requests[0].drain_first && outcome_q.size() > 0)
                    && ((requests_sent >= 700 && requests_sent < 1100)
                        || $urandom_range(0, 99) >= 10)) begin
                    next_req = pending_requests.pop_front();
                    ev_cmd   <= next_req.cmd;
                    ev_note  <= next_req.note;
                    ev_vel   <= next_req.velocity;
                    ev_valid <= 1'b1;
                end else begin
                    ev_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check, then pick the next ready level
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_ready && voice_results.valid) begin
                check_result();
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else if (!hold_done && results_seen == 300) begin
                // Hold off long enough for the queue to fill and back up the input
                hold_done = 1'b1;
                hold_left = 120;
                res_ready <= 1'b0;
            end else begin
                res_ready <= (results_seen >= 700 && results_seen < 1100)
                             || $urandom_range(0, 99) >= 10;
            end
        end
    end

    // Timeout
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int pool_base;
        int pick;

        for (int v = 0; v < VOICES; v++) begin
            voice_busy[v]  = 1'b0;
            voice_pitch[v] = '0;
            voice_vel[v]   = '0;
        end

        // Release on an empty table: free voices hold note 0 but must not match
        queue_request(pva_pkg::CMD_NOTE_OFF, 0, 0, 1'b0);
        // Fill the table: zero velocity, extremes, duplicate note, octave edges
        queue_request(pva_pkg::CMD_NOTE_ON, 0, 0, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_ON, 127, 127, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_ON, 60, 64, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_ON, 60, 1, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_ON, 11, 85, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_ON, 12, 42, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_ON, 13, 21, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_ON, 120, 106, 1'b0);
        // Claim on a full table
        queue_request(pva_pkg::CMD_NOTE_ON, 5, 127, 1'b0);
        // Release duplicates lowest first, then miss
        queue_request(pva_pkg::CMD_NOTE_OFF, 60, 0, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_OFF, 60, 127, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_OFF, 60, 0, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_OFF, 0, 0, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_ON, 64, 127, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_OFF, 99, 0, 1'b0);
        // Pause until everything has come back, then empty the table
        queue_request(pva_pkg::CMD_NOTE_OFF, 127, 0, 1'b1);
        queue_request(pva_pkg::CMD_NOTE_OFF, 11, 0, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_OFF, 12, 0, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_OFF, 13, 0, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_OFF, 120, 0, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_OFF, 64, 0, 1'b0);
        queue_request(pva_pkg::CMD_NOTE_OFF, 127, 0, 1'b0);

        // Random part: notes mostly from a narrow moving pool so releases hit
        pool_base = 0;
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i % 200 == 0) pool_base = $urandom_range(0, 120);
            if ($urandom_range(0, 99) < 80) pick = pool_base + $urandom_range(0, 7);
            else pick = $urandom_range(0, 127);
            queue_request(($urandom_range(0, 99) < 55) ? pva_pkg::CMD_NOTE_ON
                                                       : pva_pkg::CMD_NOTE_OFF,
                          pick, $urandom_range(0, 127), (i % 300) == 150);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Drain stimulus and outstanding results, then let the pipeline settle
        while (pending_requests.size() > 0 || ev_valid) @(posedge clk);
        while (outcome_q.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== polyphonic_voice_allocator.f =====
design/pva_pkg.sv
design/pva_event_if.sv
design/pva_result_if.sv
design/pva_queue.sv
design/pva_front.sv
design/pva_back.sv
design/polyphonic_voice_allocator.sv
sim/tb.sv
